// ===== hw/rtl/lfpd_pkg.sv =====
// Package for the line follower PD steering unit.
// Holds field widths, transaction structs, color codes and register indexes.
// No dependencies.
package lfpd_pkg;

    localparam int PosW     = 12;
    localparam int ReflW    = 10;
    localparam int SpeedW   = 9;
    localparam int ErrW     = 12;
    localparam int TermW    = 16;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 10;

    localparam logic [PosW-1:0]  PosLimit    = 12'd4000;
    localparam logic [PosW-1:0]  PosCenter   = 12'd2000;
    localparam logic [ReflW-1:0] BlackLevel  = 10'd700;
    localparam logic [ReflW-1:0] WhiteLevel  = 10'd50;
    localparam logic [ReflW-1:0] ColorTol    = 10'd25;
    localparam logic [SpeedW-1:0] MaxSpeedRst = 9'd200;

    typedef enum logic [2:0] {
        COLOR_BLACK = 3'd0,
        COLOR_GRAY  = 3'd1,
        COLOR_BROWN = 3'd2,
        COLOR_GREEN = 3'd3,
        COLOR_WHITE = 3'd4,
        COLOR_OTHER = 3'd5
    } t_color;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_GRAY_REF  = 2'd1,
        CFG_BROWN_REF = 2'd2,
        CFG_GREEN_REF = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SpeedW-1:0] max_speed;
        logic [ReflW-1:0]  gray_reference;
        logic [ReflW-1:0]  brown_reference;
        logic [ReflW-1:0]  green_reference;
    } t_cfg;

    typedef struct packed {
        logic [PosW-1:0]  line_position;
        logic [ReflW-1:0] middle_reflectance;
    } t_in_item;

    typedef struct packed {
        logic [SpeedW-1:0] left_speed;
        logic [SpeedW-1:0] right_speed;
        t_color            middle_color;
    } t_out_item;

    function automatic logic near_ref(input logic [ReflW-1:0] reading,
                                      input logic [ReflW-1:0] refv);
        logic [ReflW-1:0] lo;
        logic [ReflW:0]   hi;
        lo = (refv > ColorTol) ? refv - ColorTol : '0;
        hi = {1'b0, refv} + {1'b0, ColorTol};
        return (reading >= lo) && ({1'b0, reading} <= hi);
    endfunction

endpackage

// ===== hw/rtl/lfpd_color.sv =====
// Middle sensor color classifier, first match wins.
// Depends on lfpd_pkg.
module lfpd_color (
    input  logic [lfpd_pkg::ReflW-1:0] i_reading,
    input  lfpd_pkg::t_cfg             i_cfg,
    output lfpd_pkg::t_color           o_color
);
    import lfpd_pkg::*;

    always_comb begin
        if (i_reading >= BlackLevel) begin
            o_color = COLOR_BLACK;
        end else if (near_ref(i_reading, i_cfg.gray_reference)) begin
            o_color = COLOR_GRAY;
        end else if (near_ref(i_reading, i_cfg.brown_reference)) begin
            o_color = COLOR_BROWN;
        end else if (near_ref(i_reading, i_cfg.green_reference)) begin
            o_color = COLOR_GREEN;
        end else if (i_reading <= WhiteLevel) begin
            o_color = COLOR_WHITE;
        end else begin
            o_color = COLOR_OTHER;
        end
    end

endmodule

// ===== hw/rtl/lfpd_steer.sv =====
// PD steering term, wheel speed clamp and green halving.
// Keeps the previous error register. Depends on lfpd_pkg.
module lfpd_steer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [lfpd_pkg::PosW-1:0]   i_position,
    input  logic [lfpd_pkg::SpeedW-1:0] i_max_speed,
    input  logic                        i_halve,
    output logic [lfpd_pkg::SpeedW-1:0] o_left,
    output logic [lfpd_pkg::SpeedW-1:0] o_right
);
    import lfpd_pkg::*;

    logic [PosW-1:0]          pos_sat;
    logic signed [ErrW-1:0]   err;
    logic signed [ErrW-1:0]   err_bias;
    logic signed [ErrW-1:0]   p_term;
    logic signed [ErrW:0]     diff;
    logic signed [TermW-1:0]  d_term;
    logic signed [TermW-1:0]  term;
    logic signed [TermW:0]    top_ext;
    logic signed [TermW:0]    left_raw;
    logic signed [TermW:0]    right_raw;
    logic [SpeedW-1:0]        left_clamp;
    logic [SpeedW-1:0]        right_clamp;
    logic signed [ErrW-1:0]   r_prev_error;

    always_comb begin
        pos_sat  = (i_position > PosLimit) ? PosLimit : i_position;
        err      = signed'(pos_sat - PosCenter);
        err_bias = err + (err[ErrW-1] ? 12'sd3 : 12'sd0);
        p_term   = err_bias >>> 2;
        diff     = {err[ErrW-1], err} - {r_prev_error[ErrW-1], r_prev_error};
        d_term   = TermW'(signed'({{(TermW-ErrW-1){diff[ErrW]}}, diff}) * 16'sd6);
        term     = d_term + {{(TermW-ErrW){p_term[ErrW-1]}}, p_term};
        top_ext  = signed'({{(TermW+1-SpeedW){1'b0}}, i_max_speed});
        left_raw  = top_ext + {term[TermW-1], term};
        right_raw = top_ext - {term[TermW-1], term};

        if (left_raw[TermW]) begin
            left_clamp = '0;
        end else if (left_raw > top_ext) begin
            left_clamp = i_max_speed;
        end else begin
            left_clamp = left_raw[SpeedW-1:0];
        end

        if (right_raw[TermW]) begin
            right_clamp = '0;
        end else if (right_raw > top_ext) begin
            right_clamp = i_max_speed;
        end else begin
            right_clamp = right_raw[SpeedW-1:0];
        end

        o_left  = i_halve ? {1'b0, left_clamp[SpeedW-1:1]}  : left_clamp;
        o_right = i_halve ? {1'b0, right_clamp[SpeedW-1:1]} : right_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error <= '0;
        end else if (i_step) begin
            r_prev_error <= err;
        end
    end

endmodule

// ===== hw/rtl/line_follow_pd_color_steer_unit.sv =====
// Top level of the line follower PD steering unit: config registers,
// input register, output register. Depends on lfpd_pkg, lfpd_color, lfpd_steer.
//
//  channel   valid        stall        payload
//  input     i_in_valid   o_in_stall   i_in_data  (t_in_item)
//  output    o_out_valid  i_out_stall  o_out_data (t_out_item)
//  config    i_cfg_we     -            i_cfg_index, i_cfg_data
//
// Items pass the input register, then the output register; one transaction per
// cycle is sustained unless stalled, set by the one compute stage between them.
// Synchronous active-low reset clears both valid flags, the previous error and
// the config registers (max speed 200, references 0).
// An output stall holds the result register; the input register then holds too
// and o_in_stall rises once it is occupied.
module line_follow_pd_color_steer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  lfpd_pkg::t_in_item            i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output lfpd_pkg::t_out_item           o_out_data,
    input  logic                          i_out_stall,
    input  logic                          i_cfg_we,
    input  logic [lfpd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [lfpd_pkg::CfgDataW-1:0] i_cfg_data
);
    import lfpd_pkg::*;

    t_cfg              r_cfg;
    logic              r_s1_valid;
    t_in_item          r_s1;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              out_advance;
    logic              s1_step;
    t_color            color;
    logic [SpeedW-1:0] left;
    logic [SpeedW-1:0] right;

    assign out_advance = !r_out_valid || !i_out_stall;
    assign s1_step     = r_s1_valid && out_advance;
    assign o_in_stall  = r_s1_valid && !out_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    lfpd_color u_color (
        .i_reading (r_s1.middle_reflectance),
        .i_cfg     (r_cfg),
        .o_color   (color)
    );

    lfpd_steer u_steer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_step),
        .i_position  (r_s1.line_position),
        .i_max_speed (r_cfg.max_speed),
        .i_halve     (color == COLOR_GREEN),
        .o_left      (left),
        .o_right     (right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed       <= MaxSpeedRst;
            r_cfg.gray_reference  <= '0;
            r_cfg.brown_reference <= '0;
            r_cfg.green_reference <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_SPEED: r_cfg.max_speed       <= i_cfg_data[SpeedW-1:0];
                CFG_GRAY_REF:  r_cfg.gray_reference  <= i_cfg_data[ReflW-1:0];
                CFG_BROWN_REF: r_cfg.brown_reference <= i_cfg_data[ReflW-1:0];
                CFG_GREEN_REF: r_cfg.green_reference <= i_cfg_data[ReflW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1 <= i_in_data;
        end
        if (s1_step) begin
            r_out.left_speed   <= left;
            r_out.right_speed  <= right;
            r_out.middle_color <= color;
        end
    end

    a_left_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.left_speed <= r_cfg.max_speed))
        else $error("left speed above max speed");

    a_right_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.right_speed <= r_cfg.max_speed))
        else $error("right speed above max speed");

    a_green_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.middle_color == COLOR_GREEN)
            |-> (o_out_data.left_speed[SpeedW-1] == 1'b0
                 && o_out_data.right_speed[SpeedW-1] == 1'b0))
        else $error("green result not halved");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while pipeline full and stalled");

endmodule
